>>> src/ers_pkg.sv
// ----------------------------------------------------------------------------
// ers_pkg
// Shared widths, codes and controller/datapath link types for the erase
// range splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ers_pkg;

  localparam int ADDR_BITS  = 8;              // block address width
  localparam int CHUNK_BITS = 7;              // chunk length width
  localparam int START_W    = 10;             // request start field
  localparam int LEN_W      = 10;             // request signed length field
  localparam int CUR_W      = ADDR_BITS + 1;  // walking block pointer
  localparam int LEFT_W     = 10;             // blocks still to cover
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam int LIM_MIN = 4;
  localparam int LIM_MAX = 64;

  localparam logic [ADDR_BITS-1:0]  HIGHEST_RESET = ADDR_BITS'(99);
  localparam logic [CHUNK_BITS-1:0] CHUNK_RESET   = CHUNK_BITS'(10);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_BLOCK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT   = CFG_IDX_W'(1);

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_CHUNK     = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_BAD_START = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_NOTHING   = STATUS_W'(2);

  typedef struct packed {
    logic load;  // take the request word
    logic step;  // cut one chunk into the output register
  } ers_cmd_t;

  typedef struct packed {
    logic special;  // request resolves to a single error / empty result
    logic final_chunk;  // chunk being cut closes the request
  } ers_sts_t;

endpackage

`default_nettype wire

>>> src/erase_range_splitter_top.sv
// ----------------------------------------------------------------------------
// erase_range_splitter_top
// Cuts a block erase request (start, signed length) into erase chunks of
// at most chunk_limit blocks (limit clamped to 4..64), clipped at highest_block.
// ----------------------------------------------------------------------------
//  channel   | direction | word contents
//  s_axis    | in        | tdata: start_block[9:0], signed_length[19:10]
//  m_axis    | out       | tdata: chunk_start[7:0], chunk_length[14:8];
//            |           | tuser: status; tlast: last
//  cfg       | in        | cfg_idx_i 0 highest_block, 1 chunk_limit
//
// A request with an invalid start or zero length gives one word. Otherwise
// a setup step loads the range, then the chunk sizing adder/compare path
// produces one chunk per cycle while the output is not stalled.
// A stalled output holds the chunk stepping. A new request is taken only
// once the final word of the previous one leaves, at the earliest in the
// same cycle. Reset loads highest_block 99 and chunk_limit 10 and empties
// the output register.
`default_nettype none

module erase_range_splitter_top import ers_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // start_block, signed_length
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // chunk_start, chunk_length
  output logic [STATUS_W-1:0]        m_axis_tuser,   // status
  output logic                       m_axis_tlast
);

  ers_cmd_t              cmd;
  ers_sts_t              sts;
  logic [ADDR_BITS-1:0]  chunk_start;
  logic [CHUNK_BITS-1:0] chunk_length;

  ers_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ers_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .start_block_i   (s_axis_tdata[START_W-1:0]),
    .signed_length_i (s_axis_tdata[START_W+LEN_W-1:START_W]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .chunk_start_o   (chunk_start),
    .chunk_length_o  (chunk_length),
    .status_o        (m_axis_tuser),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_W'({chunk_length, chunk_start});

endmodule

`default_nettype wire

>>> src/ers_ctrl.sv
// ----------------------------------------------------------------------------
// ers_ctrl
// Handshake and sequencing for the splitter: accepts requests, steps the
// datapath once per chunk and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ers_ctrl import ers_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire ers_sts_t sts_i,
  output ers_cmd_t      cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_SPLIT
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   out_free;

  assign out_free    = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign out_valid_o = ovalid_q;

  always_comb begin
    cmd_o.load = in_valid_i && in_ready_o;
    cmd_o.step = (state_q == S_SPLIT) && out_free;
  end

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (cmd_o.load) begin
          if (sts_i.special) begin
            ovalid_d = 1'b1;
          end else begin
            state_d = S_SPLIT;
          end
        end
      end
      S_SPLIT: begin
        if (cmd_o.step) begin
          ovalid_d = 1'b1;
          if (sts_i.final_chunk) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

`default_nettype wire

>>> src/ers_dp.sv
// ----------------------------------------------------------------------------
// ers_dp
// Splitter datapath: configuration registers, range setup, chunk sizing
// and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module ers_dp import ers_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [START_W-1:0]    start_block_i,
  input  wire logic [LEN_W-1:0]      signed_length_i,
  input  wire ers_cmd_t              cmd_i,
  output ers_sts_t                   sts_o,
  output logic [ADDR_BITS-1:0]       chunk_start_o,
  output logic [CHUNK_BITS-1:0]      chunk_length_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic                       last_o
);

  logic [ADDR_BITS-1:0]  highest_q;
  logic [CHUNK_BITS-1:0] chunk_q;
  logic [CUR_W-1:0]      cur_q, cur_d;
  logic [LEFT_W-1:0]     left_q, left_d;

  logic [ADDR_BITS-1:0]  ostart_q, ostart_d;
  logic [CHUNK_BITS-1:0] olen_q, olen_d;
  logic [STATUS_W-1:0]   ostatus_q, ostatus_d;
  logic                  olast_q, olast_d;

  logic                  start_ok, len_zero;
  logic signed [LEN_W+1:0] low_sum;
  logic [ADDR_BITS-1:0]  low_blk;
  logic [CHUNK_BITS-1:0] lim, size_a, size;
  logic [CUR_W-1:0]      room, cur_n;
  logic [LEFT_W-1:0]     left_n;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q <= HIGHEST_RESET;
      chunk_q   <= CHUNK_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_HIGHEST_BLOCK) begin
        highest_q <= cfg_data_i[ADDR_BITS-1:0];
      end else if (cfg_idx_i == CFG_CHUNK_LIMIT) begin
        chunk_q <= cfg_data_i[CHUNK_BITS-1:0];
      end
    end
  end

  // request decode
  assign start_ok = START_W'(highest_q) >= start_block_i;
  assign len_zero = (signed_length_i == '0);
  assign low_sum  = $signed({2'b00, start_block_i})
                  + $signed({{2{signed_length_i[LEN_W-1]}}, signed_length_i})
                  + $signed((LEN_W+2)'(1));
  // clamp the low end of a backward range at block zero
  assign low_blk  = low_sum[LEN_W+1] ? '0 : low_sum[ADDR_BITS-1:0];

  // chunk sizing: limit clamp, remaining blocks, room below the top
  always_comb begin
    if (chunk_q < CHUNK_BITS'(LIM_MIN)) begin
      lim = CHUNK_BITS'(LIM_MIN);
    end else if (chunk_q > CHUNK_BITS'(LIM_MAX)) begin
      lim = CHUNK_BITS'(LIM_MAX);
    end else begin
      lim = chunk_q;
    end
    size_a = (left_q < LEFT_W'(lim)) ? left_q[CHUNK_BITS-1:0] : lim;
    room   = CUR_W'(highest_q) + CUR_W'(1) - cur_q;
    size   = (CUR_W'(size_a) > room) ? room[CHUNK_BITS-1:0] : size_a;
    cur_n  = cur_q + CUR_W'(size);
    left_n = left_q - LEFT_W'(size);
  end

  always_comb begin
    sts_o.special     = !start_ok || len_zero;
    sts_o.final_chunk = (cur_n > CUR_W'(highest_q)) || (left_n == '0);
  end

  always_comb begin
    cur_d     = cur_q;
    left_d    = left_q;
    ostart_d  = ostart_q;
    olen_d    = olen_q;
    ostatus_d = ostatus_q;
    olast_d   = olast_q;
    if (cmd_i.load) begin
      if (!start_ok) begin
        ostart_d  = '0;
        olen_d    = '0;
        ostatus_d = STATUS_BAD_START;
        olast_d   = 1'b1;
      end else if (len_zero) begin
        ostart_d  = start_block_i[ADDR_BITS-1:0];
        olen_d    = '0;
        ostatus_d = STATUS_NOTHING;
        olast_d   = 1'b1;
      end else if (!signed_length_i[LEN_W-1]) begin
        cur_d  = CUR_W'(start_block_i);
        left_d = LEFT_W'(signed_length_i);
      end else begin
        cur_d  = CUR_W'(low_blk);
        left_d = LEFT_W'(start_block_i) - LEFT_W'(low_blk) + LEFT_W'(1);
      end
    end else if (cmd_i.step) begin
      cur_d     = cur_n;
      left_d    = left_n;
      ostart_d  = cur_q[ADDR_BITS-1:0];
      olen_d    = size;
      ostatus_d = STATUS_CHUNK;
      olast_d   = sts_o.final_chunk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      left_q <= '0;
    end else begin
      cur_q  <= cur_d;
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostart_q  <= ostart_d;
    olen_q    <= olen_d;
    ostatus_q <= ostatus_d;
    olast_q   <= olast_d;
  end

  assign chunk_start_o  = ostart_q;
  assign chunk_length_o = olen_q;
  assign status_o       = ostatus_q;
  assign last_o         = olast_q;

endmodule

`default_nettype wire
